// ----- sv/dial_string_nibble_codec_unit_assert.svh -----
// Assertion macros for the dial string nibble codec.
// Included by the top level; needs no package.
`ifndef DIAL_STRING_NIBBLE_CODEC_UNIT_ASSERT_SVH
`define DIAL_STRING_NIBBLE_CODEC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSNC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/dsnc_pkg.sv -----
// Package for the dial string nibble codec: types, codes and the
// character/nibble conversion functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsnc_pkg;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int MD_W   = 6;
   localparam int CNT_W  = 5;

   localparam logic [MD_W-1:0]  MAX_DIGITS_RESET = 6'd32;
   localparam logic [0:0]       CSR_IDX_MAX_DIGITS = 1'b0;
   localparam logic [CNT_W-1:0] RESULT_CAP = 5'd17;
   localparam logic [CNT_W-1:0] DEC_COUNT = 5'd2;
   localparam logic [CNT_W-1:0] DEC_COUNT_LAST = 5'd3;

   localparam logic [3:0] CODE_STAR  = 4'hA;
   localparam logic [3:0] CODE_HASH  = 4'hB;
   localparam logic [3:0] CODE_PAUSE = 4'hC;
   localparam logic [3:0] CODE_MARK  = 4'hD;
   localparam logic [3:0] CODE_NONE  = 4'hF;
   localparam logic [7:0] FILL_BYTE  = 8'hFF;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_PAUSE = 8'h50;
   localparam logic [7:0] CHAR_MARK  = 8'h4D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } dsnc_state_type;

   typedef struct packed {
      logic load;
      logic advance;
   } dsnc_cmd_type;

   typedef struct packed {
      logic has_results;
      logic at_last;
   } dsnc_sts_type;

   function automatic logic [3:0] char_to_code(input logic [7:0] c);
      logic [3:0] code;
      code = CODE_NONE;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         code = c[3:0];
      end else if (c == CHAR_STAR) begin
         code = CODE_STAR;
      end else if (c == CHAR_HASH) begin
         code = CODE_HASH;
      end else if (c == CHAR_PAUSE) begin
         code = CODE_PAUSE;
      end else if (c == CHAR_MARK) begin
         code = CODE_MARK;
      end
      return code;
   endfunction

   function automatic logic [7:0] code_to_char(input logic [3:0] n);
      logic [7:0] c;
      case (n) inside
         [4'h0:4'h9]: c = CHAR_ZERO + {4'h0, n};
         CODE_STAR:   c = CHAR_STAR;
         CODE_HASH:   c = CHAR_HASH;
         CODE_PAUSE:  c = CHAR_PAUSE;
         CODE_MARK:   c = CHAR_MARK;
         default:     c = CHAR_NUL;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- sv/dsnc_if.sv -----
// Valid/ready channel interfaces for the dial string nibble codec.
// Request carries one character or packed byte; response one result word.
`timescale 1ns / 1ps
`default_nettype none

interface dsnc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] in_value;
   logic [7:0] total_chars;
   logic       in_last;

   modport source (output valid, mode, in_value, total_chars, in_last, input ready);
   modport sink   (input valid, mode, in_value, total_chars, in_last, output ready);
endinterface

interface dsnc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_value;
   logic       out_last;

   modport source (output valid, out_value, out_last, input ready);
   modport sink   (input valid, out_value, out_last, output ready);
endinterface

`default_nettype wire

// ----- sv/dsnc_csr.sv -----
// APB-style register block holding max_digits.
// Depends on dsnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsnc_csr
   import dsnc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready,
   output logic      [MD_W-1:0]   max_digits
);

   logic [MD_W-1:0] max_digits_ff;
   logic [MD_W-1:0] max_digits_in;
   logic            hit;

   // Bits below the word offset are ignored, as on a word-wide bus.
   assign hit = (paddr[CSR_AW-1:2] == CSR_IDX_MAX_DIGITS);

   always_comb begin
      max_digits_in = max_digits_ff;
      if (psel && penable && pwrite && hit) begin
         max_digits_in = pwdata[MD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_digits_ff <= MAX_DIGITS_RESET;
      end else begin
         max_digits_ff <= max_digits_in;
      end
   end

   assign prdata     = hit ? {{(CSR_DW-MD_W){1'b0}}, max_digits_ff} : '0;
   assign pready     = 1'b1;
   assign max_digits = max_digits_ff;

endmodule

`default_nettype wire

// ----- sv/dsnc_ctrl.sv -----
// Controller for the dial string nibble codec: takes a word, then sends
// its results one by one. Depends on dsnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsnc_ctrl
   import dsnc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire dsnc_sts_type sts,
   output dsnc_cmd_type      cmd
);

   dsnc_state_type state_ff;
   dsnc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.has_results) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/dsnc_dp.sv -----
// Datapath for the dial string nibble codec: encode state, result plan and
// the result word mux. Depends on dsnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsnc_dp
   import dsnc_pkg::*;
#(
   parameter int MAX_DIGITS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [MD_W-1:0] max_digits,
   input  wire logic            mode,
   input  wire logic [7:0]      in_value,
   input  wire logic [7:0]      total_chars,
   input  wire logic            in_last,
   input  wire dsnc_cmd_type    cmd,
   output dsnc_sts_type         sts,
   output logic      [7:0]      out_value,
   output logic                 out_last
);

   localparam int NW = $clog2(MAX_DIGITS + 2);
   localparam int LW = 7;

   logic [7:0]       chars_ff,  chars_in;
   logic [NW-1:0]    nib_ff,    nib_in;
   logic [3:0]       pend_ff,   pend_in;
   logic             mode_ff;
   logic             last_ff;
   logic [7:0]       byte_ff;
   logic [7:0]       head_ff;
   logic             head_valid_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;

   logic [LW-1:0]    limit_w;
   logic [NW-1:0]    limit;
   logic             dropped;
   logic             keep;
   logic [3:0]       code;
   logic [NW-1:0]    nib1;
   logic [NW-1:0]    nib2;
   logic [3:0]       pend1;
   logic             data_byte;
   logic             pad;
   logic [NW-1:0]    fill_raw;
   logic [CNT_W-1:0] cap;
   logic [CNT_W-1:0] fill;
   logic [CNT_W-1:0] enc_count;
   logic [CNT_W-1:0] count_next;
   logic [7:0]       head_next;
   logic             at_tail;

   always_comb begin
      limit_w   = (LW'(max_digits) < LW'(MAX_DIGITS)) ? LW'(max_digits) : LW'(MAX_DIGITS);
      limit     = NW'(limit_w);
      // Leading characters are dropped while chars_seen + limit < total_chars.
      dropped   = ({1'b0, chars_ff} + 9'(limit)) < {1'b0, total_chars};
      keep      = !dropped && (nib_ff < limit);
      code      = char_to_code(in_value);
      data_byte = keep && nib_ff[0];
      nib1      = nib_ff + NW'(keep);
      pend1     = (keep && !nib_ff[0]) ? code : pend_ff;
      pad       = in_last && nib1[0];
      nib2      = nib1 + NW'(pad);
      fill_raw  = (nib2 < limit) ? ((limit - nib2) >> 1) : '0;
      // At most one byte precedes the fill run, so the cap is 17 or 16.
      cap       = RESULT_CAP - CNT_W'(data_byte | pad);
      fill      = (8'(fill_raw) > 8'(cap)) ? cap : CNT_W'(fill_raw);
      enc_count = CNT_W'(data_byte | pad) + (in_last ? fill : '0);
      head_next = pad ? {pend1, CODE_NONE} : {pend_ff, code};
      if (mode == MODE_DECODE) begin
         count_next = in_last ? DEC_COUNT_LAST : DEC_COUNT;
      end else begin
         count_next = enc_count;
      end
   end

   always_comb begin
      chars_in = chars_ff;
      nib_in   = nib_ff;
      pend_in  = pend_ff;
      if (cmd.load && (mode == MODE_ENCODE)) begin
         if (in_last) begin
            chars_in = '0;
            nib_in   = '0;
            pend_in  = '0;
         end else begin
            chars_in = (chars_ff == 8'hFF) ? chars_ff : chars_ff + 8'd1;
            nib_in   = nib1;
            pend_in  = pend1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= '0;
         nib_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         chars_ff <= chars_in;
         nib_ff   <= nib_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff       <= mode;
         last_ff       <= in_last;
         byte_ff       <= in_value;
         head_ff       <= head_next;
         head_valid_ff <= data_byte | pad;
         count_ff      <= count_next;
         idx_ff        <= '0;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   always_comb begin
      if (mode_ff == MODE_DECODE) begin
         case (idx_ff)
            5'd0:    out_value = code_to_char(byte_ff[7:4]);
            5'd1:    out_value = code_to_char(byte_ff[3:0]);
            default: out_value = CHAR_NUL;
         endcase
      end else begin
         out_value = ((idx_ff == '0) && head_valid_ff) ? head_ff : FILL_BYTE;
      end
      // Only the closing word of a whole string is marked as last.
      at_tail         = (idx_ff == (count_ff - CNT_W'(1)));
      out_last        = last_ff && at_tail;
      sts.at_last     = at_tail;
      sts.has_results = (count_next != '0);
   end

endmodule

`default_nettype wire

// ----- sv/dial_string_nibble_codec_unit.sv -----
// Top level of the dial string nibble codec: register block, controller
// and datapath. Depends on dsnc_pkg, dsnc_if and the assertion macro header.
//
//   channel   role     handshake            payload
//   req_chan  in       valid/ready          mode, in_value, total_chars, in_last
//   rsp_chan  out      valid/ready          out_value, out_last
//   APB       config   psel/penable/pready  paddr, pwdata, prdata (max_digits)
//
// A word is taken on a req_chan handshake; its results then leave at one per
// cycle while rsp_chan is ready, N results per word (N is 0 to 17).
// The controller handles one word at a time: a new word is taken only once
// the last result of the previous one has been taken on rsp_chan.
// A stall on rsp_chan holds the current result; reset is synchronous and
// clears the encode state and max_digits to 32.
`timescale 1ns / 1ps
`default_nettype none

`include "dial_string_nibble_codec_unit_assert.svh"

module dial_string_nibble_codec_unit
   import dsnc_pkg::*;
#(
   parameter int MAX_DIGITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   dsnc_req_if.sink               req_chan,
   dsnc_rsp_if.source             rsp_chan,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);

   logic [MD_W-1:0] max_digits;
   dsnc_cmd_type    cmd;
   dsnc_sts_type    sts;
   logic            req_ready;
   logic            rsp_valid;
   logic [7:0]      out_value;
   logic            out_last;

   dsnc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .max_digits (max_digits)
   );

   dsnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dsnc_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .max_digits  (max_digits),
      .mode        (req_chan.mode),
      .in_value    (req_chan.in_value),
      .total_chars (req_chan.total_chars),
      .in_last     (req_chan.in_last),
      .cmd         (cmd),
      .sts         (sts),
      .out_value   (out_value),
      .out_last    (out_last)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.out_value = out_value;
   assign rsp_chan.out_last  = out_last;

   `DSNC_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, !req_ready, "input taken while results pending")
   `DSNC_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_chan.ready && out_last, !rsp_valid, "result sent after last word")
   `DSNC_ASSERT_NEXT(a_cfg_write, clock, reset, psel && penable && pwrite && (paddr[CSR_AW-1:2] == CSR_IDX_MAX_DIGITS), max_digits == $past(pwdata[MD_W-1:0]), "max_digits write lost")

endmodule

`default_nettype wire
